[hw/rtl/stepper_calibrate_and_run_unit_defines.svh]
// ---------------------------------------------------------------------------
// Stepper calibrate-and-run unit: assertion macros
// Shared property forms for the port checker.
// ---------------------------------------------------------------------------
`ifndef STEPPER_CALIBRATE_AND_RUN_UNIT_DEFINES_SVH
`define STEPPER_CALIBRATE_AND_RUN_UNIT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define SCRU_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define SCRU_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/scru_pkg.sv]
// ---------------------------------------------------------------------------
// Stepper calibrate-and-run unit: package
// Shared widths, request codes, coil table and the result record.
// ---------------------------------------------------------------------------
package scru_pkg;

	localparam int COUNT_BITS   = 16;
	localparam int CALIB_CYCLES = 3;

	localparam int ACT_W  = 2;
	localparam int EIGHT_W = 8;
	localparam int COIL_W = 4;
	localparam int REV_W  = 15;
	localparam int RUN_W  = 20;
	localparam int SEQ_W  = 3;
	localparam int CYC_W  = 2;
	localparam int REM_W  = 2;

	localparam logic [REV_W-1:0] REV_MAX = '1;

	typedef enum logic [ACT_W-1:0] {
		ACT_TICK   = 2'd0,
		ACT_CALIB  = 2'd1,
		ACT_RUN    = 2'd2,
		ACT_STATUS = 2'd3
	} action_t;

	// half-step pattern, listed from entry 7 down to entry 0
	localparam logic [7:0][COIL_W-1:0] COIL_TABLE = {
		4'h9, 4'h8, 4'hC, 4'h4, 4'h6, 4'h2, 4'h3, 4'h1
	};

	typedef struct packed {
		logic [COIL_W-1:0] coil_pattern;
		logic              stepped;
		logic              busy_res;
		logic              is_calibrated;
		logic [REV_W-1:0]  rev_steps;
		logic              rejected;
	} result_t;

endpackage

[hw/rtl/scru_core.sv]
// ---------------------------------------------------------------------------
// Stepper calibrate-and-run unit: sequencer core
// Holds the motor state and works out one request per enabled cycle.
// ---------------------------------------------------------------------------
module scru_core import scru_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic [ACT_W-1:0]   act,
	input  logic               level,
	input  logic [EIGHT_W-1:0] eighths,
	output result_t            res
);

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_SEEK,
		PH_LOW,
		PH_HIGH,
		PH_RUN
	} phase_t;

	localparam int SAT_W  = (COUNT_BITS > REV_W) ? COUNT_BITS : REV_W;
	localparam int DIV8_W = REV_W - 3;
	localparam int N_W    = EIGHT_W + 1;
	localparam int PROD_W = DIV8_W + N_W;

	phase_t                phase_q, phase_n;
	logic [SEQ_W-1:0]      seq_q, seq_n;
	logic [CYC_W-1:0]      cyc_q, cyc_n;
	logic [COUNT_BITS-1:0] count_q, count_n;
	logic [COUNT_BITS-1:0] quot_q, quot_n;
	logic [REM_W-1:0]      rem_q, rem_n;
	logic [REV_W-1:0]      rev_q, rev_n;
	logic                  cal_q, cal_n;
	logic [RUN_W-1:0]      run_q, run_n;
	logic [COIL_W-1:0]     coil_q, coil_n;

	logic                  busy;
	logic                  plain_step, count_step, rejected;
	logic [N_W-1:0]        n_eighths;
	logic [PROD_W-1:0]     run_prod;
	logic [RUN_W-1:0]      run_len;

	assign busy      = (phase_q != PH_IDLE);
	assign n_eighths = (eighths == '0) ? N_W'(8) : {1'b0, eighths};
	assign run_prod  = PROD_W'(rev_q[REV_W-1:3]) * PROD_W'(n_eighths);
	assign run_len   = run_prod[RUN_W-1:0];

	always_comb begin
		phase_n    = phase_q;
		seq_n      = seq_q;
		cyc_n      = cyc_q;
		count_n    = count_q;
		quot_n     = quot_q;
		rem_n      = rem_q;
		rev_n      = rev_q;
		cal_n      = cal_q;
		run_n      = run_q;
		coil_n     = coil_q;
		plain_step = 1'b0;
		count_step = 1'b0;
		rejected   = 1'b0;

		case (action_t'(act))
			ACT_TICK: begin
				case (phase_q)
					PH_RUN: begin
						if (run_q != '0) begin
							plain_step = 1'b1;
							run_n      = run_q - RUN_W'(1);
						end
						if (run_q <= RUN_W'(1)) begin
							phase_n = PH_IDLE;
						end
					end
					PH_SEEK: begin
						if (level) begin
							plain_step = 1'b1;
						end else begin
							phase_n    = PH_LOW;
							count_step = 1'b1;
						end
					end
					PH_LOW: begin
						count_step = 1'b1;
						if (level) begin
							phase_n = PH_HIGH;
						end
					end
					PH_HIGH: begin
						if (level) begin
							count_step = 1'b1;
						end else begin
							cyc_n = cyc_q + CYC_W'(1);
							if (cyc_n >= CYC_W'(CALIB_CYCLES)) begin
								// last sensor cycle: latch the quotient, no step
								rev_n   = (SAT_W'(quot_q) > SAT_W'(REV_MAX)) ?
									REV_MAX : REV_W'(quot_q);
								cal_n   = 1'b1;
								phase_n = PH_IDLE;
							end else begin
								// same low sample counts in the next low phase
								phase_n    = PH_LOW;
								count_step = 1'b1;
							end
						end
					end
					default: ;
				endcase
			end
			ACT_CALIB: begin
				if (busy) begin
					rejected = 1'b1;
				end else begin
					count_n = '0;
					quot_n  = '0;
					rem_n   = '0;
					cyc_n   = '0;
					phase_n = PH_SEEK;
				end
			end
			ACT_RUN: begin
				if (busy || !cal_q) begin
					rejected = 1'b1;
				end else begin
					run_n   = run_len;
					phase_n = (run_len != '0) ? PH_RUN : PH_IDLE;
				end
			end
			default: ;
		endcase

		if (plain_step || count_step) begin
			coil_n = COIL_TABLE[seq_q];
			seq_n  = seq_q + SEQ_W'(1);
		end

		// saturating count; quotient by the cycle count tracked alongside
		if (count_step && (count_q != '1)) begin
			count_n = count_q + COUNT_BITS'(1);
			if (rem_q == REM_W'(CALIB_CYCLES - 1)) begin
				rem_n  = '0;
				quot_n = quot_q + COUNT_BITS'(1);
			end else begin
				rem_n = rem_q + REM_W'(1);
			end
		end
	end

	always_comb begin
		res.coil_pattern  = coil_n;
		res.stepped       = plain_step | count_step;
		res.busy_res      = (phase_n != PH_IDLE);
		res.is_calibrated = cal_n;
		res.rev_steps     = rev_n;
		res.rejected      = rejected;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			seq_q   <= '0;
			cyc_q   <= '0;
			count_q <= '0;
			quot_q  <= '0;
			rem_q   <= '0;
			rev_q   <= '0;
			cal_q   <= 1'b0;
			run_q   <= '0;
			coil_q  <= '0;
		end else if (en) begin
			phase_q <= phase_n;
			seq_q   <= seq_n;
			cyc_q   <= cyc_n;
			count_q <= count_n;
			quot_q  <= quot_n;
			rem_q   <= rem_n;
			rev_q   <= rev_n;
			cal_q   <= cal_n;
			run_q   <= run_n;
			coil_q  <= coil_n;
		end
	end

endmodule

[hw/rtl/stepper_calibrate_and_run_unit.sv]
// Path: a request accepted into the input register is worked on by the core,
// and its result is captured in the result register, where the receiver takes it.
// Throughput: one request per cycle; the input and result registers advance
// together whenever the result register is empty or being taken.
// Reset: arst_n clears the sequencer state, coils off, uncalibrated, and
// empties both registers.
// ---------------------------------------------------------------------------
// Stepper calibrate-and-run unit: top level
// Input register, sequencer core and result register.
// ---------------------------------------------------------------------------
module stepper_calibrate_and_run_unit import scru_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [ACT_W-1:0]   action,
	input  logic               sensor_level,
	input  logic [EIGHT_W-1:0] run_eighths,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [COIL_W-1:0]  coil_pattern,
	output logic               stepped,
	output logic               busy_res,
	output logic               is_calibrated,
	output logic [REV_W-1:0]   rev_steps,
	output logic               rejected
);

	logic               valid_s1, valid_s2;
	logic [ACT_W-1:0]   act_s1;
	logic               level_s1;
	logic [EIGHT_W-1:0] eighths_s1;
	result_t            res, res_s2;
	logic               advance;

	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	scru_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (advance),
		.act     (act_s1),
		.level   (level_s1),
		.eighths (eighths_s1),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// payload: hold unless the stage moves
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			act_s1     <= action;
			level_s1   <= sensor_level;
			eighths_s1 <= run_eighths;
		end
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign out_valid     = valid_s2;
	assign coil_pattern  = res_s2.coil_pattern;
	assign stepped       = res_s2.stepped;
	assign busy_res      = res_s2.busy_res;
	assign is_calibrated = res_s2.is_calibrated;
	assign rev_steps     = res_s2.rev_steps;
	assign rejected      = res_s2.rejected;

endmodule

[hw/rtl/scru_checker.sv]
// ---------------------------------------------------------------------------
// Stepper calibrate-and-run unit: port checker
// Watches the result-side top-level ports and is bound to the top level.
// ---------------------------------------------------------------------------
`include "stepper_calibrate_and_run_unit_defines.svh"

module scru_checker import scru_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              out_valid,
	input logic              out_ready,
	input logic [COIL_W-1:0] coil_pattern,
	input logic              stepped,
	input logic              is_calibrated,
	input logic [REV_W-1:0]  rev_steps,
	input logic              rejected
);

	`SCRU_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(coil_pattern) && $stable(rev_steps), "result changed while stalled")
	`SCRU_ASSERT_NOW(a_reject_no_step, out_valid && rejected, !stepped, "refused request stepped the motor")
	`SCRU_ASSERT_NOW(a_step_pattern, out_valid && stepped, ($countones(coil_pattern) == 1) || ($countones(coil_pattern) == 2), "stepped to an invalid coil pattern")
	`SCRU_ASSERT_NOW(a_uncal_zero, out_valid && !is_calibrated, rev_steps == '0, "steps per revolution set before calibration")

endmodule

bind stepper_calibrate_and_run_unit scru_checker u_scru_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.coil_pattern  (coil_pattern),
	.stepped       (stepped),
	.is_calibrated (is_calibrated),
	.rev_steps     (rev_steps),
	.rejected      (rejected)
);

[test/stepper_calibrate_and_run_checker.sv]
// ---------------------------------------------------------------------------
// Stepper calibrate-and-run unit: result checker
// Watches both channels, keeps its own copy of the sequencer state, works out
// the result of every accepted request and compares it with what comes out.
// ---------------------------------------------------------------------------
module stepper_calibrate_and_run_checker import scru_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic [ACT_W-1:0]   action,
	input  logic               sensor_level,
	input  logic [EIGHT_W-1:0] run_eighths,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic [COIL_W-1:0]  coil_pattern,
	input  logic               stepped,
	input  logic               busy_res,
	input  logic               is_calibrated,
	input  logic [REV_W-1:0]   rev_steps,
	input  logic               rejected,
	output int                 fail_count,
	output int                 outstanding,
	output logic               model_busy,
	output int                 results_seen,
	output int                 calibs_done,
	output int                 steps_made,
	output int                 refusals
);

	typedef enum logic [2:0] {
		SQ_IDLE,
		SQ_SEEK,
		SQ_LOW,
		SQ_HIGH,
		SQ_RUN
	} seq_phase_t;

	seq_phase_t            ph;
	logic [SEQ_W-1:0]      seq_idx;
	logic [CYC_W-1:0]      cyc_cnt;
	logic [COUNT_BITS-1:0] step_cnt;
	logic [REV_W-1:0]      rev_reg;
	logic                  cal_flag;
	logic [RUN_W-1:0]      run_left;
	logic [COIL_W-1:0]     coil_now;
	result_t               due_results[$];
	result_t               exp_res;

	function automatic void step_coils();
		coil_now = COIL_TABLE[seq_idx];
		seq_idx  = seq_idx + 1'b1;
	endfunction

	// calibration steps count towards the revolution, saturating at the top
	function automatic void count_step();
		step_coils();
		if (step_cnt != '1)
			step_cnt = step_cnt + 1'b1;
	endfunction

	task automatic check_field(input string fname, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", fname, want, got);
			fail_count++;
		end
	endtask

	task automatic advance_sequencer(input action_t act, input logic lvl,
			input logic [EIGHT_W-1:0] eig);
		result_t               r;
		logic                  moved;
		logic                  refused;
		logic                  was_busy;
		logic [31:0]           span;
		logic [COUNT_BITS-1:0] q;
		moved    = 1'b0;
		refused  = 1'b0;
		was_busy = (ph != SQ_IDLE);
		case (act)
			ACT_TICK: begin
				if (ph == SQ_RUN) begin
					if (run_left != 0) begin
						step_coils();
						moved    = 1'b1;
						run_left = run_left - 1'b1;
					end
					if (run_left == 0)
						ph = SQ_IDLE;
				end else if (ph != SQ_IDLE) begin
					// one sample may pass from seek or high into low in the same tick
					if (ph == SQ_SEEK) begin
						if (lvl) begin
							step_coils();
							moved = 1'b1;
						end else
							ph = SQ_LOW;
					end
					if (!moved && ph == SQ_HIGH) begin
						if (lvl) begin
							count_step();
							moved = 1'b1;
						end else begin
							cyc_cnt = cyc_cnt + 1'b1;
							if (cyc_cnt >= CALIB_CYCLES) begin
								q        = COUNT_BITS'(step_cnt / CALIB_CYCLES);
								rev_reg  = (q > REV_MAX) ? REV_MAX : q[REV_W-1:0];
								cal_flag = 1'b1;
								ph       = SQ_IDLE;
								calibs_done++;
							end else
								ph = SQ_LOW;
						end
					end
					if (!moved && ph == SQ_LOW) begin
						if (lvl)
							ph = SQ_HIGH;
						count_step();
						moved = 1'b1;
					end
				end
			end
			ACT_CALIB: begin
				if (was_busy)
					refused = 1'b1;
				else begin
					step_cnt = '0;
					cyc_cnt  = '0;
					ph       = SQ_SEEK;
				end
			end
			ACT_RUN: begin
				if (was_busy || !cal_flag)
					refused = 1'b1;
				else begin
					span     = (rev_reg / 8) * ((eig == 0) ? 32'd8 : {24'd0, eig});
					run_left = span[RUN_W-1:0];
					ph       = (run_left != 0) ? SQ_RUN : SQ_IDLE;
				end
			end
			default: ;
		endcase
		r.coil_pattern  = coil_now;
		r.stepped       = moved;
		r.busy_res      = (ph != SQ_IDLE);
		r.is_calibrated = cal_flag;
		r.rev_steps     = rev_reg;
		r.rejected      = refused;
		steps_made += moved;
		refusals   += refused;
		due_results.push_back(r);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph       = SQ_IDLE;
			seq_idx  = '0;
			cyc_cnt  = '0;
			step_cnt = '0;
			rev_reg  = '0;
			cal_flag = 1'b0;
			run_left = '0;
			coil_now = '0;
			due_results.delete();
			fail_count   = 0;
			results_seen = 0;
			calibs_done  = 0;
			steps_made   = 0;
			refusals     = 0;
		end else begin
			if (out_valid && out_ready) begin
				results_seen++;
				if (due_results.size() == 0) begin
					$error("result taken with no request pending");
					fail_count++;
				end else begin
					exp_res = due_results.pop_front();
					check_field("coil_pattern", 32'(exp_res.coil_pattern),
						32'(coil_pattern));
					check_field("stepped", 32'(exp_res.stepped), 32'(stepped));
					check_field("busy_res", 32'(exp_res.busy_res), 32'(busy_res));
					check_field("is_calibrated", 32'(exp_res.is_calibrated),
						32'(is_calibrated));
					check_field("rev_steps", 32'(exp_res.rev_steps), 32'(rev_steps));
					check_field("rejected", 32'(exp_res.rejected), 32'(rejected));
				end
			end
			if (in_valid && in_ready)
				advance_sequencer(action_t'(action), sensor_level, run_eighths);
		end
		outstanding = due_results.size();
		model_busy  = (ph != SQ_IDLE);
	end

endmodule

[test/tb_stepper_calibrate_and_run_unit.sv]
// ---------------------------------------------------------------------------
// Stepper calibrate-and-run unit: testbench
// Directed requests for reset state, refusals and a tiny calibration, one
// longer calibration, then randomised calibrations, runs and noise under
// several sender and receiver idling mixes, with a long receiver hold-off.
// ---------------------------------------------------------------------------
module tb_stepper_calibrate_and_run_unit import scru_pkg::*; ();

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [ACT_W-1:0]   action = ACT_STATUS;
	logic               sensor_level = 1'b0;
	logic [EIGHT_W-1:0] run_eighths = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [COIL_W-1:0]  coil_pattern;
	logic               stepped;
	logic               busy_res;
	logic               is_calibrated;
	logic [REV_W-1:0]   rev_steps;
	logic               rejected;

	int   fail_count;
	int   outstanding;
	logic model_busy;
	int   results_seen;
	int   calibs_done;
	int   steps_made;
	int   refusals;

	int idle_pct = 0;
	int stall_pct = 0;
	int sent_total = 0;
	int hold_req = 0;
	int hold_done = 0;
	int hold_left = 0;

	stepper_calibrate_and_run_unit dut (.*);

	stepper_calibrate_and_run_checker checker_i (.*);

	always begin
		#5;
		clk = 1'b1;
		#5;
		clk = 1'b0;
	end

	// receiver: random stalls, plus one long hold-off when asked
	always @(negedge clk) begin
		if (hold_left != 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_req != 0 && hold_done == 0) begin
			out_ready <= 1'b0;
			hold_left <= 400;
			hold_done <= 1;
		end else
			out_ready <= ($urandom_range(99) >= stall_pct);
	end

	initial begin
		#30_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic offer(input action_t act, input logic lvl, input logic [EIGHT_W-1:0] eig);
		while ($urandom_range(99) < idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid     = 1'b1;
		action       = act;
		sensor_level = lvl;
		run_eighths  = eig;
		do @(posedge clk); while (!in_ready);
		sent_total++;
		@(negedge clk);
	endtask

	// tick with random sensor levels until the sequencer is idle again
	task automatic drain_busy();
		while (model_busy)
			offer(ACT_TICK, $urandom_range(1), $urandom_range(255));
	endtask

	task automatic calib_seq(input int seek_len, input int min_len, input int max_len,
			input bit noisy);
		int lo;
		int hi;
		drain_busy();
		offer(ACT_CALIB, $urandom_range(1), $urandom_range(255));
		repeat (seek_len) offer(ACT_TICK, 1'b1, $urandom_range(255));
		if (noisy)
			offer(action_t'($urandom_range(3, 1)), $urandom_range(1), $urandom_range(255));
		for (int c = 0; c < CALIB_CYCLES; c++) begin
			lo = $urandom_range(max_len, min_len);
			hi = $urandom_range(max_len, min_len);
			repeat (lo) offer(ACT_TICK, 1'b0, $urandom_range(255));
			repeat (hi) offer(ACT_TICK, 1'b1, $urandom_range(255));
		end
		offer(ACT_TICK, 1'b0, $urandom_range(255));
	endtask

	task automatic run_seq(input logic [EIGHT_W-1:0] eig, input bit noisy);
		drain_busy();
		offer(ACT_RUN, $urandom_range(1), eig);
		if (noisy)
			offer(action_t'($urandom_range(3, 1)), $urandom_range(1), $urandom_range(255));
		drain_busy();
	endtask

	task automatic request_mix(input int target);
		int start;
		int pick;
		int r;
		start = sent_total;
		while (sent_total - start < target) begin
			pick = $urandom_range(99);
			if (pick < 40)
				calib_seq($urandom_range(4), 1, 12, $urandom_range(99) < 15);
			else if (pick < 75) begin
				r = $urandom_range(99);
				if (r < 60)
					run_seq($urandom_range(8), $urandom_range(99) < 15);
				else if (r < 97)
					run_seq($urandom_range(255), $urandom_range(99) < 15);
				else
					run_seq(8'hFF, 1'b0);
			end else if (pick < 88) begin
				// broken calibration: random samples and stray commands
				drain_busy();
				offer(ACT_CALIB, $urandom_range(1), $urandom_range(255));
				repeat ($urandom_range(10, 1)) begin
					if ($urandom_range(9) == 0)
						offer(action_t'($urandom_range(3)), $urandom_range(1),
							$urandom_range(255));
					else
						offer(ACT_TICK, $urandom_range(1), $urandom_range(255));
				end
				drain_busy();
			end else begin
				repeat ($urandom_range(6, 1))
					offer(action_t'($urandom_range(3)), $urandom_range(1), $urandom_range(255));
			end
		end
	endtask

	initial begin
		int waited;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		// reset state, idle tick, run refused while uncalibrated
		offer(ACT_STATUS, 1'b0, 8'h00);
		offer(ACT_TICK, 1'b1, 8'hFF);
		offer(ACT_RUN, 1'b0, 8'hFF);
		// tiny calibration with commands refused while busy
		offer(ACT_CALIB, 1'b0, 8'h00);
		offer(ACT_TICK, 1'b1, 8'h00);
		offer(ACT_CALIB, 1'b1, 8'h00);
		offer(ACT_TICK, 1'b0, 8'h00);
		offer(ACT_RUN, 1'b0, 8'h01);
		offer(ACT_STATUS, 1'b1, 8'hFF);
		offer(ACT_TICK, 1'b1, 8'h00);
		offer(ACT_TICK, 1'b0, 8'h00);
		offer(ACT_TICK, 1'b1, 8'h00);
		offer(ACT_TICK, 1'b0, 8'h00);
		offer(ACT_TICK, 1'b1, 8'h00);
		offer(ACT_TICK, 1'b0, 8'h00);
		// steps per revolution below eight: run of zero length
		offer(ACT_RUN, 1'b0, 8'h00);
		offer(ACT_TICK, 1'b0, 8'h00);
		offer(ACT_STATUS, 1'b0, 8'h00);

		// longer calibration, one eighth of its revolution, then shrink it again
		calib_seq(2, 20, 30, 1'b0);
		run_seq(8'h01, 1'b0);
		calib_seq(0, 1, 12, 1'b0);

		hold_req = 1;
		request_mix(400);
		idle_pct = 88;
		request_mix(400);
		idle_pct  = 0;
		stall_pct = 88;
		request_mix(400);
		idle_pct  = 20;
		stall_pct = 20;
		request_mix(400);

		in_valid  = 1'b0;
		idle_pct  = 0;
		stall_pct = 0;
		waited    = 0;
		while (outstanding != 0 && waited < 5000) begin
			@(negedge clk);
			waited++;
		end
		repeat (8) @(negedge clk);
		if (outstanding != 0)
			$error("%0d expected results never arrived", outstanding);

		$display("run covered %0d requests and %0d checked results", sent_total, results_seen);
		$display("  %0d half steps, %0d calibrations, %0d refused commands",
			steps_made, calibs_done, refusals);
		if (fail_count == 0 && outstanding == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/scru_pkg.sv
hw/rtl/scru_core.sv
hw/rtl/stepper_calibrate_and_run_unit.sv
hw/rtl/scru_checker.sv
test/stepper_calibrate_and_run_checker.sv
test/tb_stepper_calibrate_and_run_unit.sv
